// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`endif

// ===== rtl/ole_pkg.sv =====
// Shared types and constants of the ordered list engine.
package ole_pkg;
	localparam int CAPACITY_DEF = 32;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_SEARCH    = 3'd6,
		OP_TRAVERSE  = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
		logic [5:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] data_out;
		logic [5:0]         index_out;
		logic [5:0]         occupancy;
		logic               final_flag;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;     // capture request
		logic exec;     // do insert/delete/search in the cells
		logic walk;     // emit one traverse element, advance cursor
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_trav;
		logic empty;
		logic walk_last;
	} stat_t;
endpackage

// ===== rtl/ole_ctrl.sv =====
// Controller state machine of the ordered list engine.
`include "assert_macros.svh"
module ole_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output ole_pkg::cmd_t cmd,
	input  ole_pkg::stat_t st
);
	import ole_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_WALK = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.is_trav && !st.empty) begin
					cmd.walk = 1'b1;
					state_d = st.walk_last ? S_IDLE : S_WALK;
				end else begin
					cmd.exec = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (st.walk_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	`CHK_IMPLY(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`CHK_NEXT(a_load_exec, clk, arst_n, cmd.load, state_q == S_EXEC)
	`CHK_IMPLY(a_cmd_excl, clk, arst_n, 1'b1, $onehot0(cmd))
endmodule

// ===== rtl/ole_dp.sv =====
// Datapath of the ordered list engine: shifting cells, count and result register.
`include "assert_macros.svh"
module ole_dp #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ole_pkg::req_t  req,
	input  ole_pkg::cmd_t  cmd,
	output ole_pkg::stat_t st,
	output logic           done,
	output ole_pkg::rsp_t  rsp
);
	import ole_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	// Position compare width: wide enough for the 6-bit field and for count + 1
	localparam int PW = (CW + 1 > 7) ? CW + 1 : 7;

	logic signed [31:0] cell_q [CAPACITY];
	logic [CW-1:0]      count_q;
	req_t               req_q;
	logic [CW-1:0]      cur_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic [PW-1:0] pos_w;
	logic [CW-1:0] tgt;
	logic          ok_ins, ok_del, is_ins, is_del, is_srch;
	logic [CAPACITY-1:0] hit;
	logic [5:0]    hit_idx;
	logic          hit_any;
	status_t       stat_c;

	assign pos_w   = PW'(req_q.position);
	assign is_ins  = (req_q.operation == OP_INS_FRONT) || (req_q.operation == OP_INS_BACK)
		|| (req_q.operation == OP_INS_POS);
	assign is_del  = (req_q.operation == OP_DEL_FRONT) || (req_q.operation == OP_DEL_BACK)
		|| (req_q.operation == OP_DEL_POS);
	assign is_srch = (req_q.operation == OP_SEARCH);

	// Decode target index and legality
	always_comb begin
		tgt = '0;
		ok_ins = 1'b0;
		ok_del = 1'b0;
		stat_c = ST_OK;
		unique case (op_t'(req_q.operation))
			OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
				if (count_q >= CW'(CAPACITY)) stat_c = ST_FULL;
				else if (req_q.operation == OP_INS_FRONT) ok_ins = 1'b1;
				else if (req_q.operation == OP_INS_BACK) begin
					ok_ins = 1'b1;
					tgt = count_q;
				end else if (pos_w == '0 || pos_w > (PW'(count_q) + 1'b1))
					stat_c = ST_BADPOS;
				else begin
					ok_ins = 1'b1;
					tgt = CW'(pos_w - 1'b1);
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
				if (count_q == '0) stat_c = ST_EMPTY;
				else if (req_q.operation == OP_DEL_FRONT) ok_del = 1'b1;
				else if (req_q.operation == OP_DEL_BACK) begin
					ok_del = 1'b1;
					tgt = count_q - 1'b1;
				end else if (pos_w == '0 || pos_w > PW'(count_q))
					stat_c = ST_BADPOS;
				else begin
					ok_del = 1'b1;
					tgt = CW'(pos_w - 1'b1);
				end
			end
			OP_SEARCH: stat_c = hit_any ? ST_OK : ST_NOTFOUND;
			OP_TRAVERSE: stat_c = ST_EMPTY;
			default: stat_c = ST_OK;
		endcase
	end

	// Per-cell compare, first match by priority encoder
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++)
			hit[i] = (CW'(i) < count_q) && (cell_q[i] == req_q.value);
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_any = 1'b1;
				hit_idx = 6'(i + 1);
			end
		end
	end

	assign st.is_trav   = (req_q.operation == OP_TRAVERSE);
	assign st.empty     = (count_q == '0);
	assign st.walk_last = ((cur_q + 1'b1) == count_q);

	// Shifting cells: each cell takes its neighbor, the new value or holds
	always_ff @(posedge clk) begin
		if (cmd.exec && ok_ins) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (CW'(i) == tgt) cell_q[i] <= req_q.value;
				else if (CW'(i) > tgt && i > 0) cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
			end
		end else if (cmd.exec && ok_del) begin
			for (int i = 0; i < CAPACITY - 1; i++)
				if (CW'(i) >= tgt) cell_q[i] <= cell_q[i + 1];
		end
	end

	// Request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) req_q <= '0;
		else if (cmd.load) req_q <= req;
	end

	// Count, cursor and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cur_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec || cmd.walk;
			if (cmd.load) cur_q <= '0;
			else if (cmd.walk) cur_q <= cur_q + 1'b1;
			if (cmd.exec && ok_ins) count_q <= count_q + 1'b1;
			else if (cmd.exec && ok_del) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			rsp_q.status     <= ST_OK;
			rsp_q.data_out   <= cell_q[cur_q[IW-1:0]];
			rsp_q.index_out  <= 6'(cur_q + 1'b1);
			rsp_q.occupancy  <= 6'(count_q);
			rsp_q.final_flag <= st.walk_last;
		end else if (cmd.exec) begin
			rsp_q.status     <= stat_c;
			rsp_q.data_out   <= ok_del ? cell_q[tgt[IW-1:0]] : '0;
			rsp_q.index_out  <= (is_srch && hit_any) ? hit_idx : '0;
			rsp_q.occupancy  <= ok_ins ? 6'(count_q + 1'b1)
				: (ok_del ? 6'(count_q - 1'b1) : 6'(count_q));
			rsp_q.final_flag <= 1'b1;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`CHK_IMPLY(a_cnt_max, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`CHK_IMPLY(a_ins_del, clk, arst_n, 1'b1, !(ok_ins && ok_del) && !(is_ins && is_del))
	`CHK_NEXT(a_walk_out, clk, arst_n, cmd.walk, done)
endmodule

// ===== rtl/ordered_list_engine.sv =====
// Top level of the ordered list engine.
// Ordered list of up to CAPACITY signed 32-bit values with deque and
// positional operations, search and traverse.
// Request channel: drive req with start high; the request is taken at an edge
// where start is high and busy is low. busy stays high until the last result.
// Result channel: each result sits on rsp for one cycle with valid high;
// rsp.final_flag marks the last result of a request. The receiver cannot stall.
// Insert, delete and search give a single result: the request is captured, then
// the shifting cells and the result register update together; the next request
// can be taken at the edge that ends the result cycle.
// Traverse gives one element per cycle, first capturing the request and then
// registering each element read at the cell read cursor; an empty list gives
// a single ST_EMPTY result.
// Search compares all cells in parallel.
// Reset empties the list; stored values are undefined until written.
module ordered_list_engine #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ole_pkg::req_t req,
	output logic          valid,
	output ole_pkg::rsp_t rsp
);
	import ole_pkg::*;

	cmd_t  cmd;
	stat_t st;

	ole_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .st(st)
	);

	ole_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .st(st),
		.done(valid), .rsp(rsp)
	);
endmodule

// ===== tb/tb_ordered_list_engine.sv =====
// Testbench for the ordered list engine: random and directed list requests checked against a list predictor.
`timescale 1ns / 100ps

class list_scoreboard;
	ole_pkg::rsp_t pending[$];
	logic signed [31:0] elems[$];
	int n_err;

	function void push_rsp(ole_pkg::status_t st, logic signed [31:0] d, int idx, logic fin);
		ole_pkg::rsp_t r;
		r.status = st;
		r.data_out = d;
		r.index_out = idx[5:0];
		r.occupancy = 6'(elems.size());
		r.final_flag = fin;
		pending.push_back(r);
	endfunction

	// Apply one accepted request to the list and queue its expected results.
	function void note_request(ole_pkg::req_t rq, int cap);
		int n;
		int p;
		logic signed [31:0] v;
		bit hit;
		n = elems.size();
		p = rq.position;
		hit = 0;
		case (ole_pkg::op_t'(rq.operation))
			ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_BACK, ole_pkg::OP_INS_POS: begin
				if (n >= cap) push_rsp(ole_pkg::ST_FULL, 0, 0, 1);
				else if (rq.operation == ole_pkg::OP_INS_FRONT) begin
					elems.push_front(rq.value);
					push_rsp(ole_pkg::ST_OK, 0, 0, 1);
				end else if (rq.operation == ole_pkg::OP_INS_BACK) begin
					elems.push_back(rq.value);
					push_rsp(ole_pkg::ST_OK, 0, 0, 1);
				end else if (p < 1 || p > n + 1) push_rsp(ole_pkg::ST_BADPOS, 0, 0, 1);
				else begin
					elems.insert(p - 1, rq.value);
					push_rsp(ole_pkg::ST_OK, 0, 0, 1);
				end
			end
			ole_pkg::OP_DEL_FRONT, ole_pkg::OP_DEL_BACK, ole_pkg::OP_DEL_POS: begin
				if (n == 0) push_rsp(ole_pkg::ST_EMPTY, 0, 0, 1);
				else if (rq.operation == ole_pkg::OP_DEL_FRONT) begin
					v = elems.pop_front();
					push_rsp(ole_pkg::ST_OK, v, 0, 1);
				end else if (rq.operation == ole_pkg::OP_DEL_BACK) begin
					v = elems.pop_back();
					push_rsp(ole_pkg::ST_OK, v, 0, 1);
				end else if (p < 1 || p > n) push_rsp(ole_pkg::ST_BADPOS, 0, 0, 1);
				else begin
					v = elems[p - 1];
					elems.delete(p - 1);
					push_rsp(ole_pkg::ST_OK, v, 0, 1);
				end
			end
			ole_pkg::OP_SEARCH: begin
				for (int i = 0; i < n && !hit; i++)
					if (elems[i] == rq.value) begin
						push_rsp(ole_pkg::ST_OK, 0, i + 1, 1);
						hit = 1;
					end
				if (!hit) push_rsp(ole_pkg::ST_NOTFOUND, 0, 0, 1);
			end
			default: begin
				if (n == 0) push_rsp(ole_pkg::ST_EMPTY, 0, 0, 1);
				for (int i = 0; i < n; i++)
					push_rsp(ole_pkg::ST_OK, elems[i], i + 1, i == n - 1);
			end
		endcase
	endfunction

	function void report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		n_err++;
	endfunction

	// Compare one observed result with the oldest expectation.
	function void check_result(ole_pkg::rsp_t r);
		ole_pkg::rsp_t e;
		if (pending.size() == 0) begin
			report("unexpected result", 64'(r), 64'(0));
			return;
		end
		e = pending.pop_front();
		if (r.status !== e.status) report("status", 64'(r.status), 64'(e.status));
		if (r.data_out !== e.data_out)
			report("data_out", 64'(unsigned'(r.data_out)), 64'(unsigned'(e.data_out)));
		if (r.index_out !== e.index_out)
			report("index_out", 64'(r.index_out), 64'(e.index_out));
		if (r.occupancy !== e.occupancy)
			report("occupancy", 64'(r.occupancy), 64'(e.occupancy));
		if (r.final_flag !== e.final_flag)
			report("final_flag", 64'(r.final_flag), 64'(e.final_flag));
	endfunction
endclass

module tb_ordered_list_engine;
	localparam int CAP = ole_pkg::CAPACITY_DEF;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic valid;
	ole_pkg::req_t req = '0;
	ole_pkg::rsp_t rsp;
	list_scoreboard sb;
	bit quiet;

	ordered_list_engine u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .valid(valid), .rsp(rsp)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Result monitor
	always @(posedge clk)
		if (arst_n && valid) sb.check_result(rsp);

	// Present one request and hold it until accepted; sometimes a random gap first.
	task automatic send(ole_pkg::op_t op, logic signed [31:0] v, logic [5:0] p);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		req <= {op, v, p};
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_request({op, v, p}, CAP);
	endtask

	// Random value: often from a small pool so searches hit, sometimes extremes.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom_range(0, 7);
		endcase
	endfunction

	initial begin
		int n;
		logic [2:0] op;
		sb = new();
		quiet = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty-list cases, then positional inserts, search, traverse and deletes
		send(ole_pkg::OP_TRAVERSE, 0, 0);
		send(ole_pkg::OP_DEL_FRONT, 0, 0);
		send(ole_pkg::OP_DEL_BACK, 0, 0);
		send(ole_pkg::OP_DEL_POS, 0, 1);
		send(ole_pkg::OP_SEARCH, 5, 0);
		send(ole_pkg::OP_INS_POS, 32'sh7fffffff, 0);
		send(ole_pkg::OP_INS_POS, 32'sh7fffffff, 2);
		send(ole_pkg::OP_INS_POS, 32'sh7fffffff, 1);
		send(ole_pkg::OP_INS_FRONT, 32'sh80000000, 6'h3f);
		send(ole_pkg::OP_INS_BACK, -1, 0);
		send(ole_pkg::OP_INS_POS, 7, 4);
		send(ole_pkg::OP_INS_POS, 9, 2);
		send(ole_pkg::OP_SEARCH, -1, 0);
		send(ole_pkg::OP_SEARCH, 123, 0);
		send(ole_pkg::OP_TRAVERSE, 0, 0);
		send(ole_pkg::OP_DEL_POS, 0, 0);
		send(ole_pkg::OP_DEL_POS, 0, 6);
		send(ole_pkg::OP_DEL_POS, 0, 5);
		send(ole_pkg::OP_DEL_POS, 0, 2);
		send(ole_pkg::OP_DEL_FRONT, 0, 0);
		send(ole_pkg::OP_DEL_BACK, 0, 0);
		// Fill to capacity, refuse inserts, then traverse and delete the last element
		while (sb.elems.size() < CAP) send(ole_pkg::OP_INS_BACK, $urandom, 6'($urandom));
		send(ole_pkg::OP_INS_FRONT, 1, 0);
		send(ole_pkg::OP_INS_POS, 1, 6'h3f);
		send(ole_pkg::OP_TRAVERSE, 0, 0);
		send(ole_pkg::OP_DEL_POS, 0, CAP);

		// Random: swing between filling and draining phases
		for (int k = 0; k < 105; k++) begin
			if (k > 85) quiet = 1;
			n = sb.elems.size();
			case ($urandom_range(0, 9))
				0, 1, 2: op = (k / 40) % 2 ? 3'($urandom_range(3, 5)) : 3'($urandom_range(0, 2));
				3, 4: op = 3'($urandom_range(0, 5));
				5, 6: op = ole_pkg::OP_SEARCH;
				7: op = ole_pkg::OP_TRAVERSE;
				default: op = 3'($urandom_range(0, 7));
			endcase
			send(ole_pkg::op_t'(op), pick_value(),
				6'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, n + 2)));
		end
		start <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.n_err == 0) $display("tb_ordered_list_engine: clean");
		else $display("tb_ordered_list_engine: errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb_ordered_list_engine: errors");
		$finish;
	end
endmodule
